// ===== rtl/lpsu_pkg.sv =====
// ----------------------------------------------------------------------------
// lpsu_pkg
// Types, codes and constants shared by the lottery priority scheduler unit.
// ----------------------------------------------------------------------------
package lpsu_pkg;

    localparam int TICKET_BASE = 40;
    localparam int NICE_LOW    = -20;
    localparam int NICE_HIGH   = 20;
    localparam int RAND_W      = 31;
    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 2;
    // Reciprocal of 41 scaled by 2^17, exact for magnitudes up to 2560.
    localparam int RECIP       = 3197;
    localparam int RECIP_SHIFT = 17;

    localparam logic [2:0] REQ_START   = 3'd0;
    localparam logic [2:0] REQ_STOP    = 3'd1;
    localparam logic [2:0] REQ_QUANTUM = 3'd2;
    localparam logic [2:0] REQ_BALANCE = 3'd3;
    localparam logic [2:0] REQ_DRAW    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_USED = 2'd1;
    localparam logic [1:0] ST_BUSY     = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] CFG_LOTTERY = 2'd0;
    localparam logic [1:0] CFG_TOP     = 2'd1;
    localparam logic [1:0] CFG_BOTTOM  = 2'd2;
    localparam logic [1:0] CFG_QCOUNT  = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_B_MUL, S_B_DIV, S_B_CHK, S_S_WR, S_Q_UPD,
        S_D1_A, S_D1_B, S_D_MOD, S_D_WAIT, S_D2_A, S_D2_B, S_D_WIN,
        S_BAL_A, S_BAL_B, S_BAL_W, S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RD_IDX, RD_SLOT, RD_PARENT
    } rd_src_t;

    typedef enum logic [2:0] {
        WR_NONE, WR_START, WR_QUANT, WR_WIN, WR_BAL
    } wr_kind_t;

    typedef struct packed {
        logic [5:0]  tickets;
        logic [4:0]  cur;
        logic [4:0]  base;
        logic [15:0] slice;
    } rec_t;

    typedef struct packed {
        logic       ready;
        logic       set_status;
        logic [1:0] status_code;
        logic       clear_use;
        logic       set_use;
        rd_src_t    rd_src;
        logic       idx_clear;
        logic       idx_inc;
        logic       sum_clear;
        logic       sum_acc;
        logic       run_clear;
        logic       run_acc;
        logic       div_start;
        logic       prod_load;
        logic       quot_load;
        wr_kind_t   wr_kind;
        logic       emit_status;
    } cmd_t;

    typedef struct packed {
        logic       req_fire;
        logic [2:0] req_type;
        logic       slot_oor;
        logic       slot_used;
        logic       parent_used;
        logic       inherit;
        logic       base_bad;
        logic       sum_zero;
        logic       elig;
        logic       win;
        logic       top_differs;
        logic       bal_cond;
        logic       idx_last;
        logic       div_done;
        logic       out_free;
    } stat_t;

endpackage

// ===== rtl/lpsu_if.sv =====
// ----------------------------------------------------------------------------
// lpsu_if
// Request and result channels of the lottery priority scheduler unit.
// ----------------------------------------------------------------------------
interface lpsu_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [4:0]  slot;
    logic signed [5:0] nice_value;
    logic [15:0] quantum;
    logic        inherit_mode;
    logic        system_process;
    logic [4:0]  parent_slot;
    logic [30:0] rand_value;

    modport source (output valid, input ready, output req_type, slot, nice_value,
                    quantum, inherit_mode, system_process, parent_slot, rand_value);
    modport sink (input valid, output ready, input req_type, slot, nice_value,
                  quantum, inherit_mode, system_process, parent_slot, rand_value);
endinterface

interface lpsu_rsp_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [4:0]  target_slot;
    logic [4:0]  new_priority;
    logic [15:0] slot_quantum;
    logic [1:0]  status;
    logic        last_item;

    modport source (output valid, input ready, output item_kind, target_slot,
                    new_priority, slot_quantum, status, last_item);
    modport sink (input valid, output ready, input item_kind, target_slot,
                  new_priority, slot_quantum, status, last_item);
endinterface

// ===== rtl/lpsu_mod.sv =====
// ----------------------------------------------------------------------------
// lpsu_mod
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lpsu_mod #(
    parameter int SW = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lpsu_pkg::RAND_W-1:0]   dividend,
    input  logic [SW-1:0]                 divisor,
    output logic [SW-1:0]                 remainder,
    output logic                          done
);
    localparam int CW = $clog2(lpsu_pkg::RAND_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [SW-1:0]               rem_reg, rem_next;
    logic [lpsu_pkg::RAND_W-1:0] q_reg, q_next;
    logic [SW:0]                 trial;

    always_comb
    begin
        trial     = {rem_reg, q_reg[lpsu_pkg::RAND_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
                rem_next = SW'(trial - {1'b0, divisor});
            else
                rem_next = SW'(trial);
            q_next   = {q_reg[lpsu_pkg::RAND_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(lpsu_pkg::RAND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign remainder = rem_reg;
    assign done      = done_reg;
endmodule

// ===== rtl/lpsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpsu_ctrl
// Request sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
module lpsu_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  lpsu_pkg::stat_t stat,
    output lpsu_pkg::cmd_t  cmd
);
    lpsu_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lpsu_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpsu_pkg::S_IDLE:
                if (stat.req_fire)
                    state_next = lpsu_pkg::S_DECODE;
            lpsu_pkg::S_DECODE:
                case (stat.req_type)
                    lpsu_pkg::REQ_START:
                        state_next = (stat.slot_oor || stat.slot_used) ?
                                     lpsu_pkg::S_FINISH : lpsu_pkg::S_B_MUL;
                    lpsu_pkg::REQ_STOP:
                        state_next = stat.slot_used ? lpsu_pkg::S_D1_A : lpsu_pkg::S_FINISH;
                    lpsu_pkg::REQ_QUANTUM:
                        state_next = stat.slot_used ? lpsu_pkg::S_Q_UPD : lpsu_pkg::S_FINISH;
                    lpsu_pkg::REQ_BALANCE:
                        state_next = lpsu_pkg::S_BAL_A;
                    lpsu_pkg::REQ_DRAW:
                        state_next = lpsu_pkg::S_D1_A;
                    default:
                        state_next = lpsu_pkg::S_FINISH;
                endcase
            lpsu_pkg::S_B_MUL:
                state_next = lpsu_pkg::S_B_DIV;
            lpsu_pkg::S_B_DIV:
                state_next = lpsu_pkg::S_B_CHK;
            lpsu_pkg::S_B_CHK:
                if (stat.base_bad || (stat.inherit && !stat.parent_used))
                    state_next = lpsu_pkg::S_FINISH;
                else
                    state_next = lpsu_pkg::S_S_WR;
            lpsu_pkg::S_S_WR:
                if (stat.out_free)
                    state_next = lpsu_pkg::S_FINISH;
            lpsu_pkg::S_Q_UPD:
                if (stat.out_free)
                    state_next = lpsu_pkg::S_D1_A;
            lpsu_pkg::S_D1_A:
                state_next = lpsu_pkg::S_D1_B;
            lpsu_pkg::S_D1_B:
                state_next = stat.idx_last ? lpsu_pkg::S_D_MOD : lpsu_pkg::S_D1_A;
            lpsu_pkg::S_D_MOD:
                state_next = stat.sum_zero ? lpsu_pkg::S_FINISH : lpsu_pkg::S_D_WAIT;
            lpsu_pkg::S_D_WAIT:
                if (stat.div_done)
                    state_next = lpsu_pkg::S_D2_A;
            lpsu_pkg::S_D2_A:
                state_next = lpsu_pkg::S_D2_B;
            lpsu_pkg::S_D2_B:
                if (stat.elig && stat.win)
                    state_next = stat.top_differs ? lpsu_pkg::S_D_WIN : lpsu_pkg::S_FINISH;
                else
                    state_next = stat.idx_last ? lpsu_pkg::S_FINISH : lpsu_pkg::S_D2_A;
            lpsu_pkg::S_D_WIN:
                if (stat.out_free)
                    state_next = lpsu_pkg::S_FINISH;
            lpsu_pkg::S_BAL_A:
                state_next = lpsu_pkg::S_BAL_B;
            lpsu_pkg::S_BAL_B:
                if (stat.bal_cond)
                    state_next = lpsu_pkg::S_BAL_W;
                else
                    state_next = stat.idx_last ? lpsu_pkg::S_FINISH : lpsu_pkg::S_BAL_A;
            lpsu_pkg::S_BAL_W:
                if (stat.out_free)
                    state_next = stat.idx_last ? lpsu_pkg::S_FINISH : lpsu_pkg::S_BAL_A;
            lpsu_pkg::S_FINISH:
                if (stat.out_free)
                    state_next = lpsu_pkg::S_IDLE;
            default:
                state_next = lpsu_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_src = lpsu_pkg::RD_IDX;
        cmd.wr_kind = lpsu_pkg::WR_NONE;
        unique case (state_reg)
            lpsu_pkg::S_IDLE:
                cmd.ready = 1'b1;
            lpsu_pkg::S_DECODE:
                case (stat.req_type)
                    lpsu_pkg::REQ_START:
                    begin
                        if (stat.slot_oor)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = lpsu_pkg::ST_NOT_USED;
                        end
                        else if (stat.slot_used)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = lpsu_pkg::ST_BUSY;
                        end
                    end
                    lpsu_pkg::REQ_STOP:
                    begin
                        if (!stat.slot_used)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = lpsu_pkg::ST_NOT_USED;
                        end
                        else
                        begin
                            cmd.clear_use = 1'b1;
                            cmd.idx_clear = 1'b1;
                            cmd.sum_clear = 1'b1;
                        end
                    end
                    lpsu_pkg::REQ_QUANTUM:
                    begin
                        cmd.rd_src = lpsu_pkg::RD_SLOT;
                        if (!stat.slot_used)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = lpsu_pkg::ST_NOT_USED;
                        end
                    end
                    lpsu_pkg::REQ_BALANCE:
                        cmd.idx_clear = 1'b1;
                    lpsu_pkg::REQ_DRAW:
                    begin
                        cmd.idx_clear = 1'b1;
                        cmd.sum_clear = 1'b1;
                    end
                    default:
                        cmd.ready = 1'b0;
                endcase
            lpsu_pkg::S_B_MUL:
                cmd.prod_load = 1'b1;
            lpsu_pkg::S_B_DIV:
                cmd.quot_load = 1'b1;
            lpsu_pkg::S_B_CHK:
            begin
                cmd.rd_src = lpsu_pkg::RD_PARENT;
                if (stat.base_bad)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = lpsu_pkg::ST_INVALID;
                end
                else if (stat.inherit && !stat.parent_used)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = lpsu_pkg::ST_NOT_USED;
                end
            end
            lpsu_pkg::S_S_WR:
            begin
                cmd.rd_src = lpsu_pkg::RD_PARENT;
                if (stat.out_free)
                begin
                    cmd.wr_kind = lpsu_pkg::WR_START;
                    cmd.set_use = 1'b1;
                end
            end
            lpsu_pkg::S_Q_UPD:
            begin
                cmd.rd_src = lpsu_pkg::RD_SLOT;
                if (stat.out_free)
                begin
                    cmd.wr_kind   = lpsu_pkg::WR_QUANT;
                    cmd.idx_clear = 1'b1;
                    cmd.sum_clear = 1'b1;
                end
            end
            lpsu_pkg::S_D1_A:
                cmd.ready = 1'b0;
            lpsu_pkg::S_D1_B:
            begin
                cmd.sum_acc = stat.elig;
                cmd.idx_inc = !stat.idx_last;
            end
            lpsu_pkg::S_D_MOD:
                cmd.div_start = !stat.sum_zero;
            lpsu_pkg::S_D_WAIT:
                if (stat.div_done)
                begin
                    cmd.idx_clear = 1'b1;
                    cmd.run_clear = 1'b1;
                end
            lpsu_pkg::S_D2_A:
                cmd.ready = 1'b0;
            lpsu_pkg::S_D2_B:
            begin
                cmd.run_acc = stat.elig;
                cmd.idx_inc = !(stat.elig && stat.win) && !stat.idx_last;
            end
            lpsu_pkg::S_D_WIN:
                if (stat.out_free)
                    cmd.wr_kind = lpsu_pkg::WR_WIN;
            lpsu_pkg::S_BAL_A:
                cmd.ready = 1'b0;
            lpsu_pkg::S_BAL_B:
                cmd.idx_inc = !stat.bal_cond && !stat.idx_last;
            lpsu_pkg::S_BAL_W:
                if (stat.out_free)
                begin
                    cmd.wr_kind = lpsu_pkg::WR_BAL;
                    cmd.idx_inc = !stat.idx_last;
                end
            lpsu_pkg::S_FINISH:
                cmd.emit_status = stat.out_free;
            default:
                cmd.ready = 1'b0;
        endcase
    end
endmodule

// ===== rtl/lpsu_dp.sv =====
// ----------------------------------------------------------------------------
// lpsu_dp
// Datapath: slot table, configuration, base priority math, draw sums and
// the result register.
// ----------------------------------------------------------------------------
module lpsu_dp #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    lpsu_req_if.sink                         req,
    lpsu_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [lpsu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lpsu_pkg::CFG_W-1:0]       cfg_data,
    input  lpsu_pkg::cmd_t                   cmd,
    output lpsu_pkg::stat_t                  stat
);
    localparam int IW = $clog2(SLOT_COUNT);
    localparam int SW = $clog2(SLOT_COUNT * (lpsu_pkg::TICKET_BASE + lpsu_pkg::NICE_HIGH) + 1);

    logic [4:0] lq_reg, top_reg, bot_reg;
    logic [5:0] qc_reg;

    logic [2:0]        req_type_reg;
    logic [4:0]        slot_reg;
    logic signed [5:0] nice_reg;
    logic [15:0]       quantum_reg;
    logic              inherit_reg;
    logic              sys_reg;
    logic [4:0]        parent_reg;
    logic [30:0]       rand_reg;
    logic [1:0]        status_reg;

    logic [SLOT_COUNT-1:0] in_use_reg;
    lpsu_pkg::rec_t        mem [SLOT_COUNT];
    lpsu_pkg::rec_t        rd_reg;
    logic [IW-1:0]         idx_reg;
    logic [SW-1:0]         sum_reg;
    logic [SW-1:0]         run_reg;
    logic signed [13:0]    prod_reg;
    logic signed [7:0]     quot_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [4:0]  out_slot_reg;
    logic [4:0]  out_prio_reg;
    logic [15:0] out_slice_reg;
    logic [1:0]  out_status_reg;
    logic        out_last_reg;

    logic              req_fire;
    logic [IW-1:0]     slot_idx, par_idx, rd_addr, wr_addr;
    logic              slot_oor, par_oor;
    logic signed [5:0] nice_c;
    logic signed [6:0] tk_s;
    logic signed [7:0] tk_plus;
    logic signed [6:0] span;
    logic [11:0]       mag;
    logic [23:0]       recip_prod;
    logic [6:0]        qm;
    logic signed [8:0] base;
    logic              in_range;
    logic signed [6:0] top_m1;
    logic [4:0]        q_cur;
    logic [SW-1:0]     tk_w;
    logic [SW-1:0]     run_next;
    logic [SW-1:0]     lucky;
    logic              div_done;
    lpsu_pkg::rec_t    wr_rec;
    logic              wr_en;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lq_reg  <= 5'd17;
            top_reg <= 5'd16;
            bot_reg <= 5'd18;
            qc_reg  <= 6'd19;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lpsu_pkg::CFG_LOTTERY: lq_reg  <= cfg_data[4:0];
                lpsu_pkg::CFG_TOP:     top_reg <= cfg_data[4:0];
                lpsu_pkg::CFG_BOTTOM:  bot_reg <= cfg_data[4:0];
                lpsu_pkg::CFG_QCOUNT:  qc_reg  <= cfg_data;
                default:               qc_reg  <= qc_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_type_reg <= req.req_type;
            slot_reg     <= req.slot;
            nice_reg     <= req.nice_value;
            quantum_reg  <= req.quantum;
            inherit_reg  <= req.inherit_mode;
            sys_reg      <= req.system_process;
            parent_reg   <= req.parent_slot;
            rand_reg     <= req.rand_value;
            status_reg   <= lpsu_pkg::ST_OK;
        end
        else if (cmd.set_status)
            status_reg <= cmd.status_code;
    end

    assign slot_oor = {27'd0, slot_reg} >= 32'(SLOT_COUNT);
    assign par_oor  = {27'd0, parent_reg} >= 32'(SLOT_COUNT);
    assign slot_idx = IW'(slot_reg);
    assign par_idx  = IW'(parent_reg);

    always_comb
    begin
        if (nice_reg < -6'sd20)
            nice_c = -6'sd20;
        else if (nice_reg > 6'sd20)
            nice_c = 6'sd20;
        else
            nice_c = nice_reg;
    end

    assign tk_s    = 7'(lpsu_pkg::TICKET_BASE) - 7'(nice_c);
    assign tk_plus = 8'(tk_s) - 8'(lpsu_pkg::NICE_LOW);
    assign span    = $signed({2'b00, bot_reg}) - $signed({2'b00, top_reg}) + 7'sd1;
    assign mag     = prod_reg[13] ? 12'(-prod_reg) : 12'(prod_reg);
    assign recip_prod = 24'(mag) * 24'(lpsu_pkg::RECIP);
    assign qm      = 7'(recip_prod >> lpsu_pkg::RECIP_SHIFT);
    assign base    = $signed({4'b0000, top_reg}) + 9'(quot_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.prod_load)
            prod_reg <= 14'(tk_plus) * 14'(span);
        if (cmd.quot_load)
            quot_reg <= prod_reg[13] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    end

    always_comb
    begin
        case (cmd.rd_src)
            lpsu_pkg::RD_SLOT:   rd_addr = slot_idx;
            lpsu_pkg::RD_PARENT: rd_addr = par_idx;
            default:             rd_addr = idx_reg;
        endcase
    end

    assign in_range = (rd_reg.cur >= top_reg) && (rd_reg.cur <= bot_reg);
    assign top_m1   = $signed({2'b00, top_reg}) - 7'sd1;
    assign q_cur    = in_range ? lq_reg :
                      ($signed({2'b00, rd_reg.cur}) < top_m1) ? rd_reg.cur + 5'd1 : rd_reg.cur;

    always_comb
    begin
        wr_rec  = rd_reg;
        wr_addr = idx_reg;
        wr_en   = 1'b1;
        case (cmd.wr_kind)
            lpsu_pkg::WR_START:
            begin
                wr_addr        = slot_idx;
                wr_rec.tickets = tk_s[5:0];
                wr_rec.base    = base[4:0];
                wr_rec.cur     = !inherit_reg ? base[4:0] : (sys_reg ? rd_reg.cur : lq_reg);
                wr_rec.slice   = inherit_reg ? rd_reg.slice : quantum_reg;
            end
            lpsu_pkg::WR_QUANT:
            begin
                wr_addr    = slot_idx;
                wr_rec.cur = q_cur;
            end
            lpsu_pkg::WR_WIN:
                wr_rec.cur = top_reg;
            lpsu_pkg::WR_BAL:
                wr_rec.cur = rd_reg.cur - 5'd1;
            default:
                wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_rec;
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_use_reg <= '0;
        else if (cmd.clear_use)
            in_use_reg[slot_idx] <= 1'b0;
        else if (cmd.set_use)
            in_use_reg[slot_idx] <= 1'b1;
    end

    assign tk_w     = SW'(rd_reg.tickets);
    assign run_next = run_reg + tk_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (cmd.idx_clear)
            idx_reg <= '0;
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_clear)
            sum_reg <= '0;
        else if (cmd.sum_acc)
            sum_reg <= sum_reg + tk_w;
        if (cmd.run_clear)
            run_reg <= '0;
        else if (cmd.run_acc)
            run_reg <= run_next;
    end

    lpsu_mod #(
        .SW (SW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (rand_reg),
        .divisor   (sum_reg),
        .remainder (lucky),
        .done      (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (wr_en || cmd.emit_status)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            out_kind_reg   <= lpsu_pkg::KIND_UPDATE;
            out_slot_reg   <= 5'(wr_addr);
            out_prio_reg   <= wr_rec.cur;
            out_slice_reg  <= wr_rec.slice;
            out_status_reg <= lpsu_pkg::ST_OK;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.emit_status)
        begin
            out_kind_reg   <= lpsu_pkg::KIND_STATUS;
            out_slot_reg   <= slot_reg;
            out_prio_reg   <= 5'd0;
            out_slice_reg  <= 16'd0;
            out_status_reg <= status_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.item_kind    = out_kind_reg;
    assign rsp.target_slot  = out_slot_reg;
    assign rsp.new_priority = out_prio_reg;
    assign rsp.slot_quantum = out_slice_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.last_item    = out_last_reg;

    always_comb
    begin
        stat             = '0;
        stat.req_fire    = req_fire;
        stat.req_type    = req_type_reg;
        stat.slot_oor    = slot_oor;
        stat.slot_used   = !slot_oor && in_use_reg[slot_idx];
        stat.parent_used = !par_oor && in_use_reg[par_idx];
        stat.inherit     = inherit_reg;
        stat.base_bad    = base[8] || (base > 9'sd31) || (base >= $signed({3'b000, qc_reg}));
        stat.sum_zero    = sum_reg == '0;
        stat.elig        = in_use_reg[idx_reg] && in_range && (rd_reg.cur == lq_reg);
        stat.win         = run_next > lucky;
        stat.top_differs = rd_reg.cur != top_reg;
        stat.bal_cond    = in_use_reg[idx_reg] && (rd_reg.cur > rd_reg.base) && !in_range;
        stat.idx_last    = idx_reg == IW'(SLOT_COUNT - 1);
        stat.div_done    = div_done;
        stat.out_free    = !out_valid_reg;
    end
endmodule

// ===== rtl/lottery_priority_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// lottery_priority_scheduler_unit
// Process slot table with lottery based promotion of user-range slots.
// ----------------------------------------------------------------------------
// One request is taken at a time; every request ends with one status item,
// preceded by an update item for each slot record that it writes. A stop or
// draw makes up to two sweeps over the slot table through its single read
// port, around a bit-serial remainder; a quantum expiry writes its slot and
// then runs a draw, and a balance tick makes one sweep. A stalled result
// channel holds the sequence.
module lottery_priority_scheduler_unit #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    lpsu_req_if.sink                         req,
    lpsu_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [lpsu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lpsu_pkg::CFG_W-1:0]       cfg_data
);
    lpsu_pkg::cmd_t  cmd;
    lpsu_pkg::stat_t stat;

    lpsu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    lpsu_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );
endmodule

// ===== tb/lpsu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsu_checker
// Watches the request, result and register-write ports of the scheduler,
// keeps its own copy of the slot table, predicts the update and status items
// of every request transfer and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module lpsu_checker #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    lpsu_req_if                            req,
    lpsu_rsp_if                            rsp,
    input  logic                           cfg_we,
    input  logic [lpsu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpsu_pkg::CFG_W-1:0]     cfg_data,
    output int                             errors,
    output int                             pending,
    output int                             n_updates,
    output int                             n_requests
);

    typedef struct packed {
        logic        kind;
        logic [4:0]  tslot;
        logic [4:0]  prio;
        logic [15:0] slice;
        logic [1:0]  st;
        logic        last;
    } sched_item_t;

    sched_item_t      sched_expect_q[$];
    logic [4:0]       lottery_q, top_q, bottom_q;
    logic [5:0]       qcount;
    logic             in_use  [SLOT_COUNT];
    logic [5:0]       tickets [SLOT_COUNT];
    logic [4:0]       cur_prio[SLOT_COUNT];
    logic [4:0]       base_prio[SLOT_COUNT];
    logic [15:0]      slice_len[SLOT_COUNT];

    assign pending = sched_expect_q.size();

    task automatic report(input string what, input int got, input int want);
        errors++;
        if (errors <= 30)
            $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic bit user_range(input int s);
        return cur_prio[s] >= top_q && cur_prio[s] <= bottom_q;
    endfunction

    function automatic void push_update(input int s);
        sched_item_t it;
        it = '{lpsu_pkg::KIND_UPDATE, s[4:0], cur_prio[s], slice_len[s],
               lpsu_pkg::ST_OK, 1'b0};
        sched_expect_q.push_back(it);
    endfunction

    function automatic bit lottery_member(input int s);
        return in_use[s] && user_range(s) && cur_prio[s] == lottery_q;
    endfunction

    task automatic run_lottery(input logic [30:0] rnd);
        int unsigned total, lucky, running;
        total = 0;
        running = 0;
        for (int s = 0; s < SLOT_COUNT; s++)
            if (lottery_member(s))
                total += tickets[s];
        if (total != 0)
        begin
            lucky = rnd % total;
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                if (lottery_member(s))
                begin
                    running += tickets[s];
                    if (running > lucky)
                    begin
                        if (cur_prio[s] != top_q)
                        begin
                            cur_prio[s] = top_q;
                            push_update(s);
                        end
                        break;
                    end
                end
            end
        end
    endtask

    function automatic logic [1:0] start_slot(input int s, input logic signed [5:0] nice_in,
                                              input logic [15:0] q, input logic inh,
                                              input logic sys, input int p);
        int nice, tk, span, base;
        if (s >= SLOT_COUNT)
            return lpsu_pkg::ST_NOT_USED;
        if (in_use[s])
            return lpsu_pkg::ST_BUSY;
        nice = nice_in;
        if (nice < lpsu_pkg::NICE_LOW)
            nice = lpsu_pkg::NICE_LOW;
        if (nice > lpsu_pkg::NICE_HIGH)
            nice = lpsu_pkg::NICE_HIGH;
        tk = lpsu_pkg::TICKET_BASE - nice;
        span = int'(bottom_q) - int'(top_q) + 1;
        base = int'(top_q) + ((tk - lpsu_pkg::NICE_LOW) * span) /
               (lpsu_pkg::NICE_HIGH - lpsu_pkg::NICE_LOW + 1);
        if (base < 0 || base > 31 || base >= int'(qcount))
            return lpsu_pkg::ST_INVALID;
        if (inh)
        begin
            if (p >= SLOT_COUNT || !in_use[p])
                return lpsu_pkg::ST_NOT_USED;
            cur_prio[s] = sys ? cur_prio[p] : lottery_q;
            slice_len[s] = slice_len[p];
        end
        else
        begin
            cur_prio[s] = base[4:0];
            slice_len[s] = q;
        end
        tickets[s] = tk[5:0];
        base_prio[s] = base[4:0];
        in_use[s] = 1'b1;
        push_update(s);
        return lpsu_pkg::ST_OK;
    endfunction

    task automatic predict_request();
        logic [1:0]  st;
        int          s;
        sched_item_t done;
        st = lpsu_pkg::ST_OK;
        s = req.slot;
        case (req.req_type)
            lpsu_pkg::REQ_START:
                st = start_slot(s, req.nice_value, req.quantum, req.inherit_mode,
                                req.system_process, req.parent_slot);
            lpsu_pkg::REQ_STOP:
                if (s >= SLOT_COUNT || !in_use[s])
                begin
                    st = lpsu_pkg::ST_NOT_USED;
                end
                else
                begin
                    in_use[s] = 1'b0;
                    run_lottery(req.rand_value);
                end
            lpsu_pkg::REQ_QUANTUM:
                if (s >= SLOT_COUNT || !in_use[s])
                begin
                    st = lpsu_pkg::ST_NOT_USED;
                end
                else
                begin
                    if (user_range(s))
                        cur_prio[s] = lottery_q;
                    else if (int'(cur_prio[s]) < int'(top_q) - 1)
                        cur_prio[s] = cur_prio[s] + 1;
                    push_update(s);
                    run_lottery(req.rand_value);
                end
            lpsu_pkg::REQ_BALANCE:
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (in_use[i] && cur_prio[i] > base_prio[i] && !user_range(i))
                    begin
                        cur_prio[i] = cur_prio[i] - 1;
                        push_update(i);
                    end
            lpsu_pkg::REQ_DRAW:
                run_lottery(req.rand_value);
            default: ;
        endcase
        done = '{lpsu_pkg::KIND_STATUS, req.slot, 5'd0, 16'd0, st, 1'b1};
        sched_expect_q.push_back(done);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_item_t want;
        if (!rst_n)
        begin
            lottery_q = 5'd17;
            top_q = 5'd16;
            bottom_q = 5'd18;
            qcount = 6'd19;
            for (int i = 0; i < SLOT_COUNT; i++)
                in_use[i] = 1'b0;
            sched_expect_q.delete();
            errors = 0;
            n_updates = 0;
            n_requests = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (sched_expect_q.size() == 0)
                begin
                    report("unexpected result, kind", rsp.item_kind, 0);
                end
                else
                begin
                    want = sched_expect_q.pop_front();
                    if (want.kind == lpsu_pkg::KIND_UPDATE)
                        n_updates++;
                    if (rsp.item_kind !== want.kind)
                        report("item_kind", rsp.item_kind, want.kind);
                    if (rsp.target_slot !== want.tslot)
                        report("target_slot", rsp.target_slot, want.tslot);
                    if (rsp.new_priority !== want.prio)
                        report("new_priority", rsp.new_priority, want.prio);
                    if (rsp.slot_quantum !== want.slice)
                        report("slot_quantum", rsp.slot_quantum, want.slice);
                    if (rsp.status !== want.st)
                        report("status", rsp.status, want.st);
                    if (rsp.last_item !== want.last)
                        report("last_item", rsp.last_item, want.last);
                end
            end
            if (req.valid && req.ready)
            begin
                n_requests++;
                predict_request();
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    lpsu_pkg::CFG_LOTTERY: lottery_q = cfg_data[4:0];
                    lpsu_pkg::CFG_TOP:     top_q = cfg_data[4:0];
                    lpsu_pkg::CFG_BOTTOM:  bottom_q = cfg_data[4:0];
                    lpsu_pkg::CFG_QCOUNT:  qcount = cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== tb/tb_lottery_priority_scheduler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lottery_priority_scheduler_unit
// Drives directed and random scheduling requests under several queue settings,
// with bursty requests and a stalling result side; the checker predicts and
// compares every result transfer.
// ----------------------------------------------------------------------------
module tb_lottery_priority_scheduler_unit;

    localparam int SLOTS = 32;
    localparam int CYCLE_LIMIT = 1000000;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [lpsu_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lpsu_pkg::CFG_W-1:0]     cfg_data;
    int                             errors, pending, n_updates, n_requests;
    int                             burst_left;
    int                             hold_left;
    int                             ready_mode, mode_left;
    int                             cycles;
    bit                             hold_request;

    lpsu_req_if req_ch ();
    lpsu_rsp_if rsp_ch ();

    lottery_priority_scheduler_unit #(.SLOT_COUNT(SLOTS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lpsu_checker #(.SLOT_COUNT(SLOTS)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending),
        .n_updates  (n_updates),
        .n_requests (n_requests)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_lottery_priority_scheduler_unit: FAIL");
            $finish;
        end
    end

    // result side: changing stall pattern, plus one long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_left = 0;
        ready_mode = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 600;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (ready_mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
                    default: rsp_ch.ready <= ($urandom_range(0, 9) < 2);
                endcase
            end
        end
    end

    task automatic send_req(input logic [2:0] rt, input logic [4:0] s,
                            input logic [5:0] nice, input logic [15:0] q,
                            input logic inh, input logic sys, input logic [4:0] par,
                            input logic [30:0] rnd);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= rt;
        req_ch.slot           <= s;
        req_ch.nice_value     <= nice;
        req_ch.quantum        <= q;
        req_ch.inherit_mode   <= inh;
        req_ch.system_process <= sys;
        req_ch.parent_slot    <= par;
        req_ch.rand_value     <= rnd;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_queues(input logic [4:0] lot, input logic [4:0] top,
                                input logic [4:0] bot, input logic [5:0] qc);
        cfg_we <= 1'b1;
        cfg_index <= lpsu_pkg::CFG_LOTTERY;
        cfg_data <= {1'b0, lot};
        @(posedge clk);
        cfg_index <= lpsu_pkg::CFG_TOP;
        cfg_data <= {1'b0, top};
        @(posedge clk);
        cfg_index <= lpsu_pkg::CFG_BOTTOM;
        cfg_data <= {1'b0, bot};
        @(posedge clk);
        cfg_index <= lpsu_pkg::CFG_QCOUNT;
        cfg_data <= qc;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_requests(input int count, input bit with_hold);
        int          pick;
        logic [2:0]  rt;
        logic [4:0]  s, par;
        for (int n = 0; n < count; n++)
        begin
            if (with_hold && n == count / 2)
                hold_request = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                rt = lpsu_pkg::REQ_START;
            else if (pick < 50)
                rt = lpsu_pkg::REQ_STOP;
            else if (pick < 75)
                rt = lpsu_pkg::REQ_QUANTUM;
            else if (pick < 85)
                rt = lpsu_pkg::REQ_BALANCE;
            else if (pick < 97)
                rt = lpsu_pkg::REQ_DRAW;
            else
                rt = 3'($urandom_range(5, 7));
            s = 5'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 31));
            par = 5'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) : $urandom_range(0, 31));
            send_req(rt, s, 6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), par,
                     31'($urandom_range(0, 32'h7FFF_FFFF)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycles = 0;
        burst_left = 0;
        hold_request = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lpsu_pkg::CFG_LOTTERY;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = lpsu_pkg::REQ_START;
        req_ch.slot = '0;
        req_ch.nice_value = '0;
        req_ch.quantum = '0;
        req_ch.inherit_mode = 1'b0;
        req_ch.system_process = 1'b0;
        req_ch.parent_slot = '0;
        req_ch.rand_value = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(lpsu_pkg::REQ_START, 5'd0, 6'd20, 16'hFFFF, 1'b0, 1'b0, 5'd0, 31'd0);
        send_req(lpsu_pkg::REQ_START, 5'd0, 6'd20, 16'h1234, 1'b0, 1'b0, 5'd0, 31'd0);
        send_req(lpsu_pkg::REQ_START, 5'd1, 6'h2C, 16'h0001, 1'b0, 1'b0, 5'd0, 31'd0);
        send_req(lpsu_pkg::REQ_START, 5'd2, 6'h20, 16'h0000, 1'b0, 1'b0, 5'd0, 31'd0);
        send_req(lpsu_pkg::REQ_START, 5'd2, 6'h1F, 16'h0000, 1'b0, 1'b0, 5'd0, 31'd0);
        send_req(lpsu_pkg::REQ_START, 5'd3, 6'd20, 16'h0000, 1'b1, 1'b1, 5'd9, 31'd0);
        send_req(lpsu_pkg::REQ_START, 5'd3, 6'd20, 16'h0000, 1'b1, 1'b1, 5'd0, 31'd0);
        send_req(lpsu_pkg::REQ_START, 5'd4, 6'd20, 16'h0000, 1'b1, 1'b0, 5'd0, 31'd0);
        send_req(lpsu_pkg::REQ_QUANTUM, 5'd0, 6'd0, 16'h0000, 1'b0, 1'b0, 5'd0,
                 31'h7FFF_FFFF);
        send_req(lpsu_pkg::REQ_DRAW, 5'd0, 6'd0, 16'h0000, 1'b0, 1'b0, 5'd0, 31'd0);
        send_req(lpsu_pkg::REQ_QUANTUM, 5'd9, 6'd0, 16'h0000, 1'b0, 1'b0, 5'd0, 31'd5);
        send_req(lpsu_pkg::REQ_QUANTUM, 5'd4, 6'd0, 16'h0000, 1'b0, 1'b0, 5'd0, 31'd21);
        send_req(lpsu_pkg::REQ_BALANCE, 5'd0, 6'd0, 16'h0000, 1'b0, 1'b0, 5'd0, 31'd0);
        send_req(lpsu_pkg::REQ_STOP, 5'd2, 6'd0, 16'h0000, 1'b0, 1'b0, 5'd0, 31'd7);
        send_req(lpsu_pkg::REQ_STOP, 5'd2, 6'd0, 16'h0000, 1'b0, 1'b0, 5'd0, 31'd7);
        send_req(3'd5, 5'd31, 6'd0, 16'h0000, 1'b0, 1'b0, 5'd0, 31'd0);
        send_req(3'd6, 5'd1, 6'd0, 16'h0000, 1'b0, 1'b0, 5'd0, 31'd0);
        send_req(3'd7, 5'd1, 6'd0, 16'h0000, 1'b0, 1'b0, 5'd0, 31'd0);
        send_req(lpsu_pkg::REQ_START, 5'd31, 6'd20, 16'hA5A5, 1'b1, 1'b1, 5'd31, 31'd0);
        send_req(lpsu_pkg::REQ_START, 5'd31, 6'd20, 16'hA5A5, 1'b0, 1'b0, 5'd31, 31'd0);
        send_req(lpsu_pkg::REQ_QUANTUM, 5'd31, 6'd0, 16'h0000, 1'b0, 1'b0, 5'd0, 31'd3);
        send_req(lpsu_pkg::REQ_DRAW, 5'd0, 6'd0, 16'h0000, 1'b0, 1'b0, 5'd0,
                 31'h4000_0000);
        random_requests(30, 1'b0);
        drain();

        write_queues(5'd5, 5'd0, 5'd31, 6'd32);
        random_requests(45, 1'b1);
        drain();
        write_queues(5'd31, 5'd31, 5'd0, 6'd1);
        random_requests(30, 1'b0);
        drain();
        write_queues(5'd31, 5'd20, 5'd31, 6'd32);
        random_requests(45, 1'b0);
        drain();
        write_queues(5'd4, 5'd2, 5'd6, 6'd10);
        random_requests(55, 1'b0);
        drain();
        write_queues(5'd0, 5'd0, 5'd3, 6'd32);
        random_requests(55, 1'b0);
        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d requests under 6 queue settings, %0d priority updates checked",
                 n_requests, n_updates);
        if (errors == 0)
            $display("tb_lottery_priority_scheduler_unit: PASS");
        else
            $display("tb_lottery_priority_scheduler_unit: FAIL");
        $finish;
    end

endmodule

// ===== lottery_priority_scheduler_unit.f =====
rtl/lpsu_pkg.sv
rtl/lpsu_if.sv
rtl/lpsu_mod.sv
rtl/lpsu_ctrl.sv
rtl/lpsu_dp.sv
rtl/lottery_priority_scheduler_unit.sv
tb/lpsu_checker.sv
tb/tb_lottery_priority_scheduler_unit.sv
